### rtl/run_length_line_table_macros.svh
// ---------------------------------------------------------------------------
// run_length_line_table_macros.svh
// Assertion macros used by the line table top level.
// ---------------------------------------------------------------------------
`ifndef RUN_LENGTH_LINE_TABLE_MACROS_SVH
`define RUN_LENGTH_LINE_TABLE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rlt_pkg.sv
// ---------------------------------------------------------------------------
// rlt_pkg
// Sizes, status codes and shared types of the run-length line table.
// ---------------------------------------------------------------------------
package rlt_pkg;

  localparam int RUN_DEPTH  = 256;
  localparam int CODE_SPACE = 65536;

  localparam int IDX_W     = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CNT_W     = $clog2(RUN_DEPTH + 1);
  localparam int LEN_W     = $clog2(CODE_SPACE + 1);
  localparam int LINE_W    = 16;
  localparam int OFF_W     = 16;
  localparam int COUNT_W   = 8;
  localparam int CMP_W     = (LEN_W > OFF_W) ? LEN_W : OFF_W;
  localparam int ENTRY_W   = LINE_W + LEN_W;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [COUNT_W-1:0] byte_count;
    logic [LINE_W-1:0]  source_line;
    logic [OFF_W-1:0]   code_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LINE_W-1:0] line_number;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;         // capture request, open the search window
    logic write;        // perform the write and set its result
    logic probe;        // read the run at the window midpoint
    logic compare;      // narrow the window with the returned run
    logic finish_empty; // set the empty-table result
    logic finish_found; // set the lookup result from the best run so far
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_lookup;
    logic empty;
    logic more;         // search window still holds runs
  } stat_t;

endpackage

### rtl/rlt_ram.sv
// ---------------------------------------------------------------------------
// rlt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/rlt_ctrl.sv
// ---------------------------------------------------------------------------
// rlt_ctrl
// Sequencer: one request at a time, write or binary-search lookup.
// ---------------------------------------------------------------------------
module rlt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  rlt_pkg::stat_t stat,
  output rlt_pkg::cmd_t  cmd
);
  import rlt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        // captured operation decides the path
        if (stat.is_lookup) begin
          state_next = S_PROBE;
        end else begin
          cmd.write  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_PROBE: begin
        priority if (stat.empty) begin
          cmd.finish_empty = 1'b1;
          state_next       = S_DONE;
        end else if (stat.more) begin
          cmd.probe  = 1'b1;
          state_next = S_CMP;
        end else begin
          cmd.finish_found = 1'b1;
          state_next       = S_DONE;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_next  = S_PROBE;
      end
      S_DONE: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/rlt_datapath.sv
// ---------------------------------------------------------------------------
// rlt_datapath
// Run table storage, code length, search window and result register.
// ---------------------------------------------------------------------------
module rlt_datapath (
  input  logic           clk,
  input  logic           rst,
  input  rlt_pkg::req_t  req,
  input  rlt_pkg::cmd_t  cmd,
  output rlt_pkg::stat_t stat,
  output rlt_pkg::rsp_t  rsp
);
  import rlt_pkg::*;

  logic [LEN_W-1:0]   code_length;
  logic [CNT_W-1:0]   run_count;
  logic [LINE_W-1:0]  last_line;
  req_t               item;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [LINE_W-1:0]  best_line;
  rsp_t               result;

  logic [LEN_W:0]     sum;
  logic               overflow;
  logic               need_run;
  logic               full;
  logic               ram_we;
  logic [CNT_W-1:0]   mid;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [LINE_W-1:0]  rd_line;
  logic [LEN_W-1:0]   rd_start;
  logic               start_le;

  assign sum      = {1'b0, code_length} + (LEN_W + 1)'(item.byte_count);
  assign overflow = (sum > (LEN_W + 1)'(CODE_SPACE));
  assign need_run = (run_count == '0) || (last_line != item.source_line);
  assign full     = (run_count == CNT_W'(RUN_DEPTH));
  assign ram_we   = cmd.write && !overflow && need_run && !full;
  assign ram_wdata = {item.source_line, code_length};

  assign mid      = lo + ((hi - lo) >> 1);
  assign rd_line  = ram_rdata[ENTRY_W-1:LEN_W];
  assign rd_start = ram_rdata[LEN_W-1:0];
  assign start_le = (CMP_W'(rd_start) <= CMP_W'(item.code_offset));

  assign stat.is_lookup = (item.operation == OP_LOOKUP);
  assign stat.empty     = (run_count == '0);
  assign stat.more      = (lo < hi);
  assign rsp            = result;

  rlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RUN_DEPTH)
  ) u_runs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (run_count[IDX_W-1:0]),
    .wdata (ram_wdata),
    .re    (cmd.probe),
    .raddr (mid[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= '0;
      run_count   <= '0;
    end else if (cmd.write && !overflow && !(need_run && full)) begin
      code_length <= sum[LEN_W-1:0];
      if (need_run) begin
        run_count <= run_count + CNT_W'(1);
      end
    end
  end

  // Mirror of the last stored run's line, so a write needs no table read.
  always_ff @(posedge clk) begin
    if (ram_we) begin
      last_line <= item.source_line;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
      lo   <= '0;
      hi   <= run_count;
    end else if (cmd.compare) begin
      if (start_le) begin
        lo        <= mid + CNT_W'(1);
        best_line <= rd_line;
      end else begin
        hi <= mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      result.line_number <= '0;
      priority if (overflow) begin
        result.status <= ST_OVERFLOW;
      end else if (need_run && full) begin
        result.status <= ST_FULL;
      end else begin
        result.status <= ST_OK;
      end
    end else if (cmd.finish_empty) begin
      result.status      <= ST_EMPTY;
      result.line_number <= '0;
    end else if (cmd.finish_found) begin
      result.status      <= ST_OK;
      result.line_number <= best_line;
    end
  end

endmodule

### rtl/run_length_line_table.sv
// Sequence: a write is answered after its single write step; a lookup over
//   n runs is answered after one table read and one compare per halving of
//   the search window, then a final step that sets the result.
// Throughput: one request at a time; the next is taken the cycle after the
//   response is taken. Reset (rst, synchronous) empties the table at once.
// ---------------------------------------------------------------------------
// run_length_line_table
// Run-length map from bytecode offsets to source line numbers.
// ---------------------------------------------------------------------------
`include "run_length_line_table_macros.svh"

module run_length_line_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rlt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rlt_pkg::rsp_t rsp
);
  import rlt_pkg::*;

  // Controller and datapath talk only through these two groups.
  cmd_t  cmd;
  stat_t stat;

  // The controller walks one request through its steps:
  //   write  - check code space, then table room when a new run is needed,
  //            append the run when needed and grow the code length together;
  //   lookup - binary search: each probe reads the midpoint run, the next
  //            cycle compares its start with the offset and halves the
  //            window, keeping the line of the latest run not above it.
  rlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the run RAM (line and start per run), the code
  // length, the search window and the response register, which holds the
  // response steady until it is taken.
  rlt_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

  // A request is never taken while a response is pending.
  `RLT_ASSERT_NOW(a_one_in_flight, req_valid && req_ready, !rsp_valid,
                  "request taken with response pending")
  // Errors and writes carry a zero line number.
  `RLT_ASSERT_NOW(a_err_line_zero, rsp_valid && (rsp.status != ST_OK),
                  rsp.line_number == '0, "error response with nonzero line")
  // One response per request: a taken response is not shown again.
  `RLT_ASSERT_NEXT(a_single_rsp, rsp_valid && rsp_ready, !rsp_valid, "response repeated")

endmodule
